[design/efr_pkg.sv]
package efr_pkg;

    // Frame limit: positions above this give a too-long error
    localparam int MAX_FRAME = 32;
    localparam int POS_W     = $clog2(MAX_FRAME + 2);
    localparam int ADDR_W    = $clog2(MAX_FRAME);

    localparam logic [7:0] ESC_FLIP = 8'h20;
    localparam logic [7:0] SUM_OK   = 8'hff;

    // Configuration register indexes
    localparam logic CFG_START_BYTE  = 1'b0;
    localparam logic CFG_ESCAPE_BYTE = 1'b1;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_UNEXP_START = 3'd1,
        STS_ZERO_LEN    = 3'd2,
        STS_TOO_LONG    = 3'd3,
        STS_BAD_SUM     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_RX,
        ST_LOAD,
        ST_SEND
    } state_t;

    typedef enum logic [1:0] {
        SRC_ERR,
        SRC_EMPTY,
        SRC_DATA
    } out_src_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     rd_first;
        logic     rd_step;
        logic     out_load;
        out_src_t out_src;
        logic     out_taken;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_valid;
        logic out_last;
        logic emit_err;
        logic emit_empty;
        logic drain;
    } stat_t;

endpackage

[design/efr_ram.sv]
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/efr_datapath.sv]
module efr_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data,
    input  efr_pkg::cmd_t       cmd,
    output efr_pkg::stat_t      stat,
    output logic [15:0]         m_tdata,   // command_code [7:0], payload_byte [15:8]
    output logic [3:0]          m_tuser,   // status [2:0], payload_valid [3]
    output logic                m_tlast
);

    localparam int PW = efr_pkg::POS_W;
    localparam int AW = efr_pkg::ADDR_W;

    logic [7:0]  start_reg, escape_reg;
    logic        hold_reg, hold_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cmdb_reg, cmdb_next;
    logic [7:0]  sum_reg, sum_next;
    logic        esc_reg, esc_next;
    logic [AW-1:0] ptr_reg, ptr_next;

    logic        out_valid_reg, out_valid_next;
    efr_pkg::status_t out_status_reg;
    logic [7:0]  out_cmd_reg, out_pay_reg;
    logic        out_pv_reg, out_last_reg;

    logic [7:0]  byte_d, sum_add;
    logic        is_start, is_esc, at_end, fail;
    efr_pkg::status_t err_code;
    logic        emit_empty, drain;
    logic        wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]  rd_data;
    logic        last_item;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= 8'd126;
            escape_reg <= 8'd125;
        end else if (cfg_valid) begin
            case (cfg_index)
                efr_pkg::CFG_START_BYTE:  start_reg  <= cfg_data;
                efr_pkg::CFG_ESCAPE_BYTE: escape_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Byte parser
    assign is_start = (s_tdata == start_reg);
    assign is_esc   = (s_tdata == escape_reg);
    assign byte_d   = esc_reg ? (s_tdata ^ efr_pkg::ESC_FLIP) : s_tdata;
    assign sum_add  = sum_reg + byte_d;
    assign at_end   = (9'(pos_reg) == ({1'b0, len_reg} + 9'd2));
    assign wr_addr  = AW'(pos_reg - PW'(3));

    always_comb begin
        hold_next  = hold_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        cmdb_next  = cmdb_reg;
        sum_next   = sum_reg;
        esc_next   = esc_reg;
        fail       = 1'b0;
        err_code   = efr_pkg::STS_OK;
        emit_empty = 1'b0;
        drain      = 1'b0;
        wr_en      = 1'b0;
        if (hold_reg) begin
            if (is_start) begin
                hold_next = 1'b0;
                pos_next  = PW'(1);
                sum_next  = 8'd0;
                esc_next  = 1'b0;
            end
        end else if (pos_reg == PW'(0)) begin
            if (is_start) begin
                pos_next = PW'(1);
            end
        end else if (is_start) begin
            fail     = 1'b1;
            err_code = efr_pkg::STS_UNEXP_START;
        end else if (is_esc) begin
            esc_next = 1'b1;
        end else begin
            esc_next = 1'b0;
            if (pos_reg == PW'(1)) begin
                if (byte_d == 8'd0) begin
                    fail     = 1'b1;
                    err_code = efr_pkg::STS_ZERO_LEN;
                end else begin
                    len_next = byte_d;
                    pos_next = PW'(2);
                end
            end else if (pos_reg == PW'(2)) begin
                cmdb_next = byte_d;
                pos_next  = PW'(3);
                sum_next  = sum_add;
            end else if (pos_reg > PW'(efr_pkg::MAX_FRAME)) begin
                fail     = 1'b1;
                err_code = efr_pkg::STS_TOO_LONG;
            end else if (at_end) begin
                if (sum_add != efr_pkg::SUM_OK) begin
                    fail     = 1'b1;
                    err_code = efr_pkg::STS_BAD_SUM;
                end else begin
                    pos_next = PW'(0);
                    sum_next = 8'd0;
                    if (len_reg == 8'd1) begin
                        emit_empty = 1'b1;
                    end else begin
                        drain = 1'b1;
                    end
                end
            end else begin
                wr_en    = 1'b1;
                pos_next = pos_reg + PW'(1);
                sum_next = sum_add;
            end
        end
        // Any error drops the frame and waits for a start byte
        if (fail) begin
            hold_next = 1'b1;
            pos_next  = PW'(0);
            sum_next  = 8'd0;
            esc_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
            pos_reg  <= '0;
            len_reg  <= 8'd0;
            cmdb_reg <= 8'd0;
            sum_reg  <= 8'd0;
            esc_reg  <= 1'b0;
        end else if (cmd.accept) begin
            hold_reg <= hold_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            cmdb_reg <= cmdb_next;
            sum_reg  <= sum_next;
            esc_reg  <= esc_next;
        end
    end

    // Payload buffer and drain pointer
    assign rd_en    = cmd.rd_first | cmd.rd_step;
    assign rd_addr  = cmd.rd_first ? AW'(0) : (ptr_reg + AW'(1));
    assign ptr_next = rd_en ? rd_addr : ptr_reg;

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
    end

    efr_ram #(
        .WIDTH(8),
        .DEPTH(efr_pkg::MAX_FRAME)
    ) u_buf (
        .aclk   (aclk),
        .wr_en  (cmd.accept & wr_en),
        .wr_addr(wr_addr),
        .wr_data(byte_d),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Last data byte of the run sits at length - 2
    assign last_item = ((9'(ptr_reg) + 9'd2) == {1'b0, len_reg});

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (cmd.out_taken) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_src)
                efr_pkg::SRC_ERR: begin
                    out_status_reg <= err_code;
                    out_cmd_reg    <= 8'd0;
                    out_pay_reg    <= 8'd0;
                    out_pv_reg     <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
                efr_pkg::SRC_EMPTY: begin
                    out_status_reg <= efr_pkg::STS_OK;
                    out_cmd_reg    <= cmdb_reg;
                    out_pay_reg    <= 8'd0;
                    out_pv_reg     <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
                default: begin
                    out_status_reg <= efr_pkg::STS_OK;
                    out_cmd_reg    <= cmdb_reg;
                    out_pay_reg    <= rd_data;
                    out_pv_reg     <= 1'b1;
                    out_last_reg   <= last_item;
                end
            endcase
        end
    end

    assign m_tdata = {out_pay_reg, out_cmd_reg};
    assign m_tuser = {out_pv_reg, out_status_reg};
    assign m_tlast = out_last_reg;

    assign stat.out_valid  = out_valid_reg;
    assign stat.out_last   = out_last_reg;
    assign stat.emit_err   = fail;
    assign stat.emit_empty = emit_empty;
    assign stat.drain      = drain;

`ifndef SYNTHESIS
    // Output register is only overwritten when empty or being taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || cmd.out_taken))
        else $error("output register overwritten");
    // A failing byte never starts a drain
    a_fail_no_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        fail |-> (!drain && !emit_empty))
        else $error("error and frame end together");
    // Position never passes the frame limit by more than one
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |-> (pos_reg <= PW'(efr_pkg::MAX_FRAME + 1)))
        else $error("frame position out of range");
`endif

endmodule

[design/efr_ctrl.sv]
module efr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           m_tready,
    input  efr_pkg::stat_t stat,
    output efr_pkg::cmd_t  cmd
);

    efr_pkg::state_t state_reg, state_next;
    logic out_free, acc;

    assign out_free = !stat.out_valid || m_tready;
    assign acc      = (state_reg == efr_pkg::ST_RX) && s_tvalid && out_free;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            efr_pkg::ST_RX: begin
                if (acc && stat.drain) begin
                    state_next = efr_pkg::ST_LOAD;
                end
            end
            efr_pkg::ST_LOAD: begin
                state_next = efr_pkg::ST_SEND;
            end
            efr_pkg::ST_SEND: begin
                if (m_tready) begin
                    state_next = stat.out_last ? efr_pkg::ST_RX : efr_pkg::ST_LOAD;
                end
            end
            default: state_next = efr_pkg::ST_RX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= efr_pkg::ST_RX;
        end else begin
            state_reg <= state_next;
        end
    end

    // Outputs
    always_comb begin
        s_tready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.rd_first  = 1'b0;
        cmd.rd_step   = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.out_src   = efr_pkg::SRC_DATA;
        cmd.out_taken = stat.out_valid && m_tready;
        case (state_reg)
            efr_pkg::ST_RX: begin
                s_tready   = out_free;
                cmd.accept = acc;
                if (acc && stat.emit_err) begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = efr_pkg::SRC_ERR;
                end else if (acc && stat.emit_empty) begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = efr_pkg::SRC_EMPTY;
                end else if (acc && stat.drain) begin
                    cmd.rd_first = 1'b1;
                end
            end
            efr_pkg::ST_LOAD: begin
                cmd.out_load = 1'b1;
                cmd.out_src  = efr_pkg::SRC_DATA;
            end
            efr_pkg::ST_SEND: begin
                cmd.rd_step = m_tready && !stat.out_last;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // Loading a data byte is always followed by presenting it
    a_load_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == efr_pkg::ST_LOAD) |=> (state_reg == efr_pkg::ST_SEND && stat.out_valid))
        else $error("data byte not presented after load");
    // No input is taken while a frame drains
    a_no_rx_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == efr_pkg::ST_RX))
        else $error("input ready during drain");
    // While presenting, the output is valid
    a_send_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == efr_pkg::ST_SEND) |-> stat.out_valid)
        else $error("send state without valid output");
`endif

endmodule

[design/escaped_frame_receiver.sv]
// Byte-stuffed frame receiver with additive checksum.
// s_ channel: one raw link byte per transfer on s_tdata.
// m_ channel: results; tdata = command and payload byte, tuser = status and
//   payload-valid flag, tlast marks the final result of a run.
// cfg channel: cfg_index 0 writes the start byte, 1 the escape byte; always
//   ready, write only while the block is idle.
// Input bytes are taken one per cycle while the output register is empty or
// being taken. An error or an empty frame gives one result the cycle after
// the byte that causes it. A good frame is drained from the payload buffer
// after its checksum byte: each data result passes a registered buffer read,
// then an output register load, and the next read is issued only when the
// previous result is taken; input is held off until the last one is taken.
// A stalled m_tready holds the result and drops s_tready for the next byte.
// Reset (aresetn low, synchronous) restores the delimiter values 0x7e and
// 0x7d, waits for a start byte and empties the output; the payload buffer
// needs no clearing pass since a frame only reads what it wrote.
module escaped_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte [7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // command_code [7:0], payload_byte [15:8]
    output logic [3:0]  m_tuser,    // status [2:0], payload_valid [3]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    efr_pkg::cmd_t  cmd;
    efr_pkg::stat_t stat;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = stat.out_valid;

    efr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    efr_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
